// File: design/ipdf_pkg.sv
// ----------------------------------------------------------------------------
// ipdf_pkg
// Shared types, constants and helper functions of the iSCSI PDU deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ipdf_pkg;

    localparam int unsigned HDR_LEN = 48;
    localparam int unsigned LEN_W   = 25;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    // byte kind doubles as framing phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_HDIG   = 3'd1,
        PH_DATA   = 3'd2,
        PH_PAD    = 3'd3,
        PH_DDIG   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HDR_BAD  = 2'd1,
        ST_DATA_BAD = 2'd2
    } status_t;

    // register indexes on the configuration port
    localparam logic [1:0] REG_HDIG_ON = 2'd0;
    localparam logic [1:0] REG_DDIG_ON = 2'd1;
    localparam logic [1:0] REG_MAX_LEN = 2'd2;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 25'(256 * 1024);

    typedef struct packed {
        logic             hdig_on;
        logic             ddig_on;
        logic [LEN_W-1:0] max_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        phase_t           kind;
        logic [5:0]       opcode;
        logic [LEN_W-1:0] seg_len;
        logic             pdu_end;
        status_t          status;
    } result_t;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                                input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic opcode_known(input logic [5:0] op);
        return op inside {[6'h00:6'h06], 6'h10, [6'h20:6'h26], 6'h31, 6'h32, 6'h3F};
    endfunction

endpackage

`default_nettype wire

// File: design/ipdf_framer.sv
// ----------------------------------------------------------------------------
// ipdf_framer
// PDU framing state, CRC32C accumulation and digest check for one byte a step.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdf_framer (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       in_byte,
    input  wire ipdf_pkg::cfg_t   cfg,
    output ipdf_pkg::result_t     res
);
    import ipdf_pkg::*;

    phase_t             phase_reg,  phase_next;
    logic [LEN_W-1:0]   cnt_reg,    cnt_next;
    logic [7:0]         ahs_reg,    ahs_next;
    logic [LEN_W-1:0]   dlen_reg,   dlen_next;
    logic [5:0]         op_reg,     op_next;
    logic [31:0]        crc_reg,    crc_next;
    logic [31:0]        shift_reg,  shift_next;
    logic               herr_reg,   herr_next;

    logic               first_byte;
    logic               hdr_last;
    logic               dig_done;
    logic [31:0]        crc_upd;
    logic [31:0]        shift_new;
    logic               mismatch;
    logic [LEN_W-1:0]   cnt_inc;
    logic [1:0]         pad_len;
    logic [LEN_W-1:0]   raw_len;
    logic [LEN_W-1:0]   hdr_len;
    logic               data_done;
    logic               pad_done;

    assign first_byte = (phase_reg == PH_HEADER) && (cnt_reg == '0);
    assign hdr_last   = (cnt_reg == LEN_W'(HDR_LEN - 1));
    assign dig_done   = (cnt_reg == LEN_W'(3));
    assign crc_upd    = crc32c_byte(first_byte ? CRC_INIT : crc_reg, in_byte);
    assign shift_new  = {shift_reg[23:0], in_byte};
    assign mismatch   = (shift_new != ~crc_reg);
    assign cnt_inc    = cnt_reg + LEN_W'(1);
    assign pad_len    = 2'(2'd0 - dlen_reg[1:0]);
    assign data_done  = (cnt_inc >= dlen_reg);
    assign pad_done   = (cnt_inc >= LEN_W'(pad_len));

    // segment length = 4 * ahs words + data segment length, zero for unknown opcodes, clamped to max_len
    assign raw_len = opcode_known(op_reg)
                   ? ({15'd0, ahs_reg, 2'b00} + {1'b0, dlen_reg[23:0]})
                   : '0;
    assign hdr_len = (raw_len > cfg.max_len) ? cfg.max_len : raw_len;

    // next state
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        ahs_next   = ahs_reg;
        dlen_next  = dlen_reg;
        op_next    = op_reg;
        crc_next   = crc_reg;
        shift_next = shift_reg;
        herr_next  = herr_reg;
        case (phase_reg)
            PH_HEADER: begin
                crc_next = crc_upd;
                if (cnt_reg == '0) begin
                    op_next   = in_byte[5:0];
                    dlen_next = '0;
                    ahs_next  = '0;
                    herr_next = 1'b0;
                end
                if (cnt_reg == LEN_W'(4)) begin
                    ahs_next = in_byte;
                end
                if (cnt_reg >= LEN_W'(5) && cnt_reg <= LEN_W'(7)) begin
                    dlen_next = {1'b0, dlen_reg[15:0], in_byte};
                end
                if (hdr_last) begin
                    dlen_next = hdr_len;
                    cnt_next  = '0;
                    if (cfg.hdig_on) begin
                        phase_next = PH_HDIG;
                        shift_next = '0;
                    end else begin
                        crc_next = CRC_INIT;
                        if (hdr_len != '0) begin
                            phase_next = PH_DATA;
                        end else if (cfg.ddig_on) begin
                            phase_next = PH_DDIG;
                            shift_next = '0;
                        end else begin
                            phase_next = PH_HEADER;
                        end
                    end
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_HDIG: begin
                shift_next = shift_new;
                cnt_next   = cnt_inc;
                if (dig_done) begin
                    herr_next = mismatch;
                    crc_next  = CRC_INIT;
                    cnt_next  = '0;
                    if (dlen_reg != '0) begin
                        phase_next = PH_DATA;
                    end else if (cfg.ddig_on) begin
                        phase_next = PH_DDIG;
                        shift_next = '0;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            PH_DATA: begin
                crc_next = crc_upd;
                cnt_next = cnt_inc;
                if (data_done) begin
                    cnt_next = '0;
                    if (pad_len != 2'd0) begin
                        phase_next = PH_PAD;
                    end else if (cfg.ddig_on) begin
                        phase_next = PH_DDIG;
                        shift_next = '0;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            PH_PAD: begin
                crc_next = crc_upd;
                cnt_next = cnt_inc;
                if (pad_done) begin
                    cnt_next = '0;
                    if (cfg.ddig_on) begin
                        phase_next = PH_DDIG;
                        shift_next = '0;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            default: begin
                shift_next = shift_new;
                cnt_next   = cnt_inc;
                if (dig_done) begin
                    phase_next = PH_HEADER;
                    cnt_next   = '0;
                end
            end
        endcase
    end

    // result for the current byte
    always_comb begin
        logic pdu_end;
        logic herr_eff;
        logic data_bad;
        pdu_end  = 1'b0;
        herr_eff = herr_reg;
        data_bad = 1'b0;
        res.seg_len = dlen_reg;
        case (phase_reg)
            PH_HEADER: begin
                herr_eff    = first_byte ? 1'b0 : herr_reg;
                pdu_end     = hdr_last && !cfg.hdig_on && (hdr_len == '0) && !cfg.ddig_on;
                res.seg_len = hdr_last ? hdr_len : '0;
            end
            PH_HDIG: begin
                herr_eff = dig_done ? mismatch : herr_reg;
                pdu_end  = dig_done && (dlen_reg == '0) && !cfg.ddig_on;
            end
            PH_DATA: begin
                pdu_end = data_done && (pad_len == 2'd0) && !cfg.ddig_on;
            end
            PH_PAD: begin
                pdu_end = pad_done && !cfg.ddig_on;
            end
            default: begin
                pdu_end  = dig_done;
                data_bad = dig_done && mismatch;
            end
        endcase
        res.data_byte = in_byte;
        res.kind      = phase_reg;
        res.opcode    = first_byte ? in_byte[5:0] : op_reg;
        res.pdu_end   = pdu_end;
        if (!pdu_end) begin
            res.status = ST_OK;
        end else if (herr_eff) begin
            res.status = ST_HDR_BAD;
        end else if (data_bad) begin
            res.status = ST_DATA_BAD;
        end else begin
            res.status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            ahs_reg   <= '0;
            dlen_reg  <= '0;
            op_reg    <= '0;
            crc_reg   <= CRC_INIT;
            shift_reg <= '0;
            herr_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            ahs_reg   <= ahs_next;
            dlen_reg  <= dlen_next;
            op_reg    <= op_next;
            crc_reg   <= crc_next;
            shift_reg <= shift_next;
            herr_reg  <= herr_next;
        end
    end

endmodule

`default_nettype wire

// File: design/iscsi_pdu_deframer_core.sv
// ----------------------------------------------------------------------------
// iscsi_pdu_deframer_core
// Frames an iSCSI byte stream into PDU sections and checks CRC32C digests.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_        in   s_tvalid / s_tready       s_tdata: in_byte
//  m_        out  m_tvalid / m_tready       m_tdata, m_tuser: byte_kind, m_tlast: pdu_end
//  apb       in   psel / penable / pready   paddr, pwdata, prdata
//
//  one byte per cycle sustained while m_tready is high; a byte waits in the input
//  register, is framed into the result register and then shows on m_
//  the framer state and crc update together for each byte, which sets the rate
//  aresetn is synchronous, active low; no clearing pass is needed
//  with m_tready low the input register still takes one more word
// ----------------------------------------------------------------------------
`default_nettype none

module iscsi_pdu_deframer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] out_byte, [13:8] pdu_opcode,
                                        // [38:14] segment_length, [40:39] pdu_status
    output logic             m_tlast,   // pdu_end
    output logic [2:0]       m_tuser,   // [2:0] byte_kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ipdf_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;
    result_t     res;
    cfg_t        cfg_reg;
    logic        advance;
    logic        accept;
    logic        cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    ipdf_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hdig_on <= 1'b0;
            cfg_reg.ddig_on <= 1'b0;
            cfg_reg.max_len <= MAX_LEN_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HDIG_ON: cfg_reg.hdig_on <= pwdata[0];
                REG_DDIG_ON: cfg_reg.ddig_on <= pwdata[0];
                REG_MAX_LEN: cfg_reg.max_len <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HDIG_ON: prdata = {31'd0, cfg_reg.hdig_on};
            REG_DDIG_ON: prdata = {31'd0, cfg_reg.ddig_on};
            REG_MAX_LEN: prdata = {{(32-LEN_W){1'b0}}, cfg_reg.max_len};
            default:     prdata = '0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.status, out_res_reg.seg_len,
                       out_res_reg.opcode, out_res_reg.data_byte};
    assign m_tlast  = out_res_reg.pdu_end;
    assign m_tuser  = out_res_reg.kind;

    // input side only blocks when both stages hold a word and the sink stalls
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // a framed word always lands in the result register
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("framed word lost");

    // digest status only ever comes with the last word of a pdu
    a_status_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_res_reg.status != ST_OK)) |-> m_tlast)
        else $error("pdu status outside pdu end");

endmodule

`default_nettype wire

// File: verif/tb_iscsi_pdu_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iscsi_pdu_deframer_core
// Streams iSCSI PDUs byte by byte into the deframer and checks every output
// word against a cycle-free framing predictor kept in the bench: header,
// digests, segment, pad, unknown opcodes, length clamping, digest errors,
// register changes inside a PDU, then random traffic under three backpressure
// patterns.
// ----------------------------------------------------------------------------

module tb_iscsi_pdu_deframer_core;
    import ipdf_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;   // [7:0] out_byte, [13:8] pdu_opcode,
                            // [38:14] segment_length, [40:39] pdu_status
    logic        m_tlast;   // pdu_end
    logic [2:0]  m_tuser;   // [2:0] byte_kind
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    iscsi_pdu_deframer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // register mirror
    logic             cfg_hdig = 1'b0;
    logic             cfg_ddig = 1'b0;
    logic [LEN_W-1:0] cfg_max  = MAX_LEN_RESET;

    // framer state as the bench sees it
    phase_t           fr_phase   = PH_HEADER;
    logic [LEN_W-1:0] fr_count   = '0;
    logic [7:0]       fr_ahs     = '0;
    logic [LEN_W-1:0] fr_len     = '0;
    logic [5:0]       fr_opcode  = '0;
    logic [31:0]      fr_crc     = CRC_INIT;
    logic [31:0]      fr_digest  = '0;
    logic             fr_hdr_bad = 1'b0;

    result_t     framed_q[$];
    result_t     oldest;
    int unsigned failures     = 0;
    int unsigned n_bytes      = 0;
    int unsigned n_pdus       = 0;
    int unsigned n_hdr_bad    = 0;
    int unsigned n_data_bad   = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned stall_cycles = 0;

    function automatic logic [31:0] crc32c_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ 32'(b);
        repeat (8) c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        return c;
    endfunction

    function automatic bit is_rfc_opcode(input logic [5:0] op);
        return (op <= 6'h06) || (op == 6'h10) || (op >= 6'h20 && op <= 6'h26) ||
               (op == 6'h31) || (op == 6'h32) || (op == 6'h3F);
    endfunction

    // segment done: go to pad, data digest or next header
    function automatic bit leave_segment();
        fr_count = '0;
        if (fr_len[1:0] != 2'd0) begin
            fr_phase = PH_PAD;
            return 1'b0;
        end
        if (cfg_ddig) begin
            fr_phase  = PH_DDIG;
            fr_digest = '0;
            return 1'b0;
        end
        fr_phase = PH_HEADER;
        return 1'b1;
    endfunction

    function automatic bit enter_segment();
        fr_crc   = CRC_INIT;
        fr_count = '0;
        if (fr_len != '0) begin
            fr_phase = PH_DATA;
            return 1'b0;
        end
        return leave_segment();
    endfunction

    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t     r;
        phase_t      kind;
        bit          ends;
        bit          data_bad;
        logic [25:0] decoded;
        logic [1:0]  pad_len;
        kind     = fr_phase;
        ends     = 1'b0;
        data_bad = 1'b0;
        decoded  = '0;
        pad_len  = 2'(0 - fr_len[1:0]);
        case (fr_phase)
            PH_HEADER: begin
                if (fr_count == '0) begin
                    fr_opcode  = b[5:0];
                    fr_len     = '0;
                    fr_ahs     = '0;
                    fr_hdr_bad = 1'b0;
                    fr_crc     = CRC_INIT;
                end
                fr_crc = crc32c_step(fr_crc, b);
                if (fr_count == 4) fr_ahs = b;
                if (fr_count >= 5 && fr_count <= 7) fr_len = {1'b0, fr_len[15:0], b};
                if (fr_count == HDR_LEN - 1) begin
                    if (is_rfc_opcode(fr_opcode))
                        decoded = {16'd0, fr_ahs, 2'b00} + {1'b0, fr_len};
                    if (decoded > {1'b0, cfg_max}) decoded = {1'b0, cfg_max};
                    fr_len = decoded[LEN_W-1:0];
                    if (cfg_hdig) begin
                        fr_phase  = PH_HDIG;
                        fr_count  = '0;
                        fr_digest = '0;
                    end else begin
                        ends = enter_segment();
                    end
                end else begin
                    fr_count++;
                end
            end
            PH_HDIG: begin
                fr_digest = {fr_digest[23:0], b};
                fr_count++;
                if (fr_count >= 4) begin
                    fr_hdr_bad = (fr_digest != ~fr_crc);
                    ends = enter_segment();
                end
            end
            PH_DATA: begin
                fr_crc = crc32c_step(fr_crc, b);
                fr_count++;
                if (fr_count >= fr_len) ends = leave_segment();
            end
            PH_PAD: begin
                fr_crc = crc32c_step(fr_crc, b);
                fr_count++;
                if (fr_count >= pad_len) begin
                    fr_count = '0;
                    if (cfg_ddig) begin
                        fr_phase  = PH_DDIG;
                        fr_digest = '0;
                    end else begin
                        fr_phase = PH_HEADER;
                        ends     = 1'b1;
                    end
                end
            end
            default: begin
                fr_digest = {fr_digest[23:0], b};
                fr_count++;
                if (fr_count >= 4) begin
                    data_bad = (fr_digest != ~fr_crc);
                    fr_phase = PH_HEADER;
                    fr_count = '0;
                    ends     = 1'b1;
                end
            end
        endcase
        r.data_byte = b;
        r.kind      = kind;
        r.opcode    = fr_opcode;
        r.pdu_end   = ends;
        // length shows from the last header byte on
        r.seg_len   = (kind == PH_HEADER && fr_phase == PH_HEADER && !ends) ? '0 : fr_len;
        r.status    = ST_OK;
        if (ends && fr_hdr_bad) r.status = ST_HDR_BAD;
        else if (ends && data_bad) r.status = ST_DATA_BAD;
        return r;
    endfunction

    // digest byte the framer waits for next, msb first, with optional bit flips
    function automatic logic [7:0] digest_byte(input logic [31:0] flip);
        return 8'(((~fr_crc) ^ flip) >> (8 * (3 - int'(fr_count))));
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (framed_q.size() == 0) begin
                $error("result word 0x%0h with nothing expected", m_tdata[7:0]);
                failures++;
            end else begin
                oldest = framed_q.pop_front();
                check_field("out_byte", 32'(oldest.data_byte), 32'(m_tdata[7:0]));
                check_field("byte_kind", 32'(oldest.kind), 32'(m_tuser));
                check_field("pdu_opcode", 32'(oldest.opcode), 32'(m_tdata[13:8]));
                check_field("segment_length", 32'(oldest.seg_len), 32'(m_tdata[38:14]));
                check_field("pdu_end", 32'(oldest.pdu_end), 32'(m_tlast));
                check_field("pdu_status", 32'(oldest.status), 32'(m_tdata[40:39]));
            end
            if (m_tlast) begin
                n_pdus++;
                if (m_tdata[40:39] == ST_HDR_BAD) n_hdr_bad++;
                if (m_tdata[40:39] == ST_DATA_BAD) n_data_bad++;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("no progress for %0d cycles", STALL_LIMIT);
                $display("iscsi_pdu_deframer_core test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        framed_q.push_back(deframe_byte(b));
        n_bytes++;
    endtask

    // hold the stream until every outstanding word has come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (framed_q.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_HDIG_ON: cfg_hdig = value[0];
            REG_DDIG_ON: cfg_ddig = value[0];
            REG_MAX_LEN: cfg_max  = value[LEN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic verify_regs();
        read_reg(REG_HDIG_ON, 32'(cfg_hdig));
        read_reg(REG_DDIG_ON, 32'(cfg_ddig));
        read_reg(REG_MAX_LEN, 32'(cfg_max));
    endtask

    task automatic apply_config(input logic hdig, input logic ddig, input logic [LEN_W-1:0] max_len);
        wait_drain();
        write_reg(REG_HDIG_ON, 32'(hdig));
        write_reg(REG_DDIG_ON, 32'(ddig));
        write_reg(REG_MAX_LEN, 32'(max_len));
        verify_regs();
    endtask

    // feed whatever the framer wants next until it is back at a header start
    task automatic finish_pdu(input logic [31:0] hflip, input logic [31:0] dflip,
                              input bit noisy_pad);
        logic [7:0] b;
        while (!(fr_phase == PH_HEADER && fr_count == '0)) begin
            case (fr_phase)
                PH_HDIG: b = digest_byte(hflip);
                PH_DDIG: b = digest_byte(dflip);
                PH_PAD:  b = noisy_pad ? 8'($urandom) : 8'h00;
                default: b = 8'($urandom);
            endcase
            push_byte(b);
        end
    endtask

    task automatic send_pdu(input logic [7:0] op_byte, input logic [7:0] ahs,
                            input logic [23:0] dsl, input logic [31:0] hflip,
                            input logic [31:0] dflip, input bit noisy_pad);
        logic [7:0] b;
        for (int i = 0; i < HDR_LEN; i++) begin
            case (i)
                0:       b = op_byte;
                4:       b = ahs;
                5:       b = dsl[23:16];
                6:       b = dsl[15:8];
                7:       b = dsl[7:0];
                default: b = 8'($urandom);
            endcase
            push_byte(b);
        end
        finish_pdu(hflip, dflip, noisy_pad);
    endtask

    task automatic test_reset_defaults();
        wait_drain();
        verify_regs();
    endtask

    task automatic test_minimal_pdu();
        // upper opcode bits are ignored
        send_pdu(8'hC0, 8'd0, 24'd0, 32'd0, 32'd0, 1'b0);
    endtask

    task automatic test_segment_and_pad();
        send_pdu(8'h01, 8'd1, 24'd5, 32'd0, 32'd0, 1'b1);
    endtask

    task automatic test_unknown_opcode();
        send_pdu(8'h07, 8'hFF, 24'hFFFFFF, 32'd0, 32'd0, 1'b0);
    endtask

    task automatic test_length_clamp();
        apply_config(1'b0, 1'b0, 25'd6);
        send_pdu(8'h20, 8'hFF, 24'hFFFFFF, 32'd0, 32'd0, 1'b1);
        apply_config(1'b0, 1'b0, 25'd0);
        send_pdu(8'h3F, 8'd3, 24'd7, 32'd0, 32'd0, 1'b0);
    endtask

    task automatic test_digests();
        apply_config(1'b1, 1'b0, MAX_LEN_RESET);
        send_pdu(8'h24, 8'd0, 24'd2, 32'h0000_0100, 32'd0, 1'b0);
        apply_config(1'b0, 1'b1, MAX_LEN_RESET);
        send_pdu(8'h05, 8'd0, 24'd9, 32'd0, 32'h8000_0000, 1'b1);
        // zero segment: digest of nothing
        send_pdu(8'h10, 8'd0, 24'd0, 32'd0, 32'd0, 1'b0);
        apply_config(1'b1, 1'b1, MAX_LEN_RESET);
        // header error wins over data error
        send_pdu(8'h31, 8'd0, 24'd3, 32'h0000_0001, 32'h0001_0000, 1'b0);
    endtask

    task automatic test_midpdu_config();
        logic [7:0] b;
        apply_config(1'b0, 1'b0, MAX_LEN_RESET);
        for (int i = 0; i < HDR_LEN; i++) begin
            if (i == 20) begin
                wait_drain();
                write_reg(REG_HDIG_ON, 32'd1);
            end
            if (i == 40) begin
                wait_drain();
                write_reg(REG_MAX_LEN, 32'd7);
            end
            case (i)
                0:       b = 8'h03;
                4, 5, 6: b = 8'h00;
                7:       b = 8'd10;
                default: b = 8'($urandom);
            endcase
            push_byte(b);
        end
        finish_pdu(32'd0, 32'd0, 1'b0);
        // flip data digest on while inside the segment
        for (int i = 0; i < HDR_LEN + 4 + 3; i++) begin
            case (i)
                0:       b = 8'h22;
                4, 5, 6: b = 8'h00;
                7:       b = 8'd6;
                default: b = (fr_phase == PH_HDIG) ? digest_byte(32'd0) : 8'($urandom);
            endcase
            push_byte(b);
        end
        wait_drain();
        write_reg(REG_DDIG_ON, 32'd1);
        finish_pdu(32'd0, 32'd0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned      start;
        logic [5:0]       op;
        logic [7:0]       ahs;
        logic [23:0]      dsl;
        logic [31:0]      hflip;
        logic [31:0]      dflip;
        logic [LEN_W-1:0] max_len;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       set_idling(12, 58);
                1:       set_idling(58, 12);
                default: set_idling(0, 0);
            endcase
            start = n_bytes;
            while (n_bytes - start < 64) begin
                if (n_bytes == start || $urandom_range(5) == 0) begin
                    case ($urandom_range(9))
                        0:       max_len = 25'd0;
                        1:       max_len = 25'd1;
                        2:       max_len = 25'd2;
                        3:       max_len = 25'd3;
                        4:       max_len = 25'd13;
                        5:       max_len = 25'd40;
                        6:       max_len = 25'd64;
                        7:       max_len = 25'd300;
                        8:       max_len = MAX_LEN_RESET;
                        default: max_len = '1;
                    endcase
                    apply_config(1'($urandom), 1'($urandom), max_len);
                end
                hflip = ($urandom_range(4) == 0) ? (32'd1 << $urandom_range(31)) : 32'd0;
                dflip = ($urandom_range(4) == 0) ? (32'd1 << $urandom_range(31)) : 32'd0;
                if (cfg_max <= 64 && $urandom_range(6) == 0) begin
                    // raw bytes, then resync on whatever the framer wants
                    repeat ($urandom_range(1, 60)) push_byte(8'($urandom));
                    finish_pdu(hflip, dflip, 1'b1);
                end else begin
                    if ($urandom_range(3) != 0) begin
                        do op = 6'($urandom); while (!is_rfc_opcode(op));
                    end else begin
                        op = 6'($urandom);
                    end
                    if (cfg_max <= 64) begin
                        // small limit keeps any decoded length short
                        ahs = 8'($urandom);
                        dsl = 24'($urandom);
                    end else begin
                        ahs = 8'($urandom_range(3));
                        dsl = {16'd0, 8'($urandom_range(20))};
                    end
                    send_pdu({2'($urandom), op}, ahs, dsl, hflip, dflip,
                             $urandom_range(3) == 0);
                end
            end
        end
    endtask

    initial begin
        rx_idle_pct = 58;
        tx_idle_pct = 12;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_minimal_pdu();
        test_segment_and_pad();
        test_unknown_opcode();
        test_length_clamp();
        test_digests();
        test_midpdu_config();
        test_random_traffic();
        wait_drain();
        repeat (16) @(posedge aclk);
        $display("%0d bytes framed into %0d PDUs, %0d header and %0d data digest errors flagged",
                 n_bytes, n_pdus, n_hdr_bad, n_data_bad);
        $display("opcode masking, unknown opcodes, both digests, limits 0 to max, three stall patterns");
        if (failures == 0 && framed_q.size() == 0) begin
            $display("iscsi_pdu_deframer_core test passed");
        end else begin
            $display("iscsi_pdu_deframer_core test failed");
        end
        $finish;
    end

endmodule
